// ----- hdl/mcbft_pkg.sv -----
package mcbft_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIMEBASE_MS_DEF  = 10;
    localparam int MAX_CHANNELS     = 8;

    localparam int CFG_W  = 4;
    localparam int CH_W   = 3;
    localparam int MS_W   = 16;
    localparam int TICK_W = 16;
    localparam int CHM_W  = 2;
    localparam int DRV_W  = 2;
    localparam int ST_W   = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // request codes on the input channel
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_OFF   = 2'd1,
        CMD_ON    = 2'd2,
        CMD_FLASH = 2'd3
    } t_cmd;

    // stored channel mode
    localparam logic [CHM_W-1:0] CHM_OFF   = 2'd0;
    localparam logic [CHM_W-1:0] CHM_ON    = 2'd1;
    localparam logic [CHM_W-1:0] CHM_FLASH = 2'd2;

    localparam logic [DRV_W-1:0] DRV_SILENT = 2'd0;
    localparam logic [DRV_W-1:0] DRV_FULL   = 2'd1;
    localparam logic [DRV_W-1:0] DRV_HALF   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_IN_USE  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE_ERR   = 2'd2;

    // one channel entry; all zero is the reset value
    typedef struct packed {
        logic [CHM_W-1:0]  mode;
        logic [TICK_W-1:0] remaining_ticks;
        logic [TICK_W-1:0] on_phase_ticks;
        logic [TICK_W-1:0] off_phase_ticks;
        logic [TICK_W-1:0] phase_countdown;
        logic              in_on_phase;
        logic [DRV_W-1:0]  drive;
    } t_chan_state;

    // one tick applied to one channel entry
    function automatic t_chan_state chan_advance(input t_chan_state s);
        t_chan_state       r;
        logic [TICK_W-1:0] cd_dec;
        r      = s;
        cd_dec = (s.phase_countdown != '0) ? s.phase_countdown - 1'b1 : s.phase_countdown;
        if (s.mode != CHM_OFF && !(s.mode == CHM_ON && s.remaining_ticks == '0)) begin
            if (s.remaining_ticks != '0) begin
                r.remaining_ticks = s.remaining_ticks - 1'b1;
            end
            if (s.remaining_ticks == TICK_W'(1)) begin
                r.mode  = CHM_OFF;
                r.drive = DRV_SILENT;
            end else if (s.mode == CHM_FLASH) begin
                r.phase_countdown = cd_dec;
                if (cd_dec == '0) begin
                    if (s.in_on_phase) begin
                        r.in_on_phase     = 1'b0;
                        r.drive           = DRV_SILENT;
                        r.phase_countdown = s.off_phase_ticks;
                    end else begin
                        r.in_on_phase     = 1'b1;
                        r.drive           = DRV_HALF;
                        r.phase_countdown = s.on_phase_ticks;
                    end
                end
            end
        end
        return r;
    endfunction

    // channel still needs ticks
    function automatic logic chan_running(input t_chan_state s);
        return (s.mode == CHM_FLASH) || (s.mode == CHM_ON && s.remaining_ticks != '0);
    endfunction

endpackage

// ----- hdl/mcbft_ms2tick.sv -----
module mcbft_ms2tick import mcbft_pkg::*; #(
    parameter int TIMEBASE_MS = TIMEBASE_MS_DEF
) (
    input  logic              i_clk,
    input  logic [MS_W-1:0]   i_ms,
    output logic [TICK_W-1:0] o_ticks
);

    // floor(2^32 / tb) + 1 gives an exact quotient for 16-bit dividends
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TIMEBASE_MS + 1);

    logic [MS_W+32:0] w_prod;

    assign w_prod = {33'd0, i_ms} * {{MS_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        o_ticks <= w_prod[MS_W+31:32];
    end

endmodule

// ----- hdl/mcbft_chan_mem.sv -----
module mcbft_chan_mem import mcbft_pkg::*; #(
    parameter int DEPTH = NUM_CHANNELS_DEF,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_chan_state   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_chan_state   i_wr_data
);

    t_chan_state      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_chan_state      r_rd_data;
    logic             r_rd_valid;
    logic             w_fwd;

    // write-first on a same-entry collision
    assign w_fwd = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= w_fwd ? i_wr_data : r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= w_fwd ? 1'b1 : r_valid[i_rd_addr];
            end
        end
    end

    // an entry never written reads as the reset state
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- hdl/multi_channel_beep_flash_timer.sv -----
// a command is accepted in idle, its times pass through the conversion registers, and the
//   result goes to the output register once it is free; only then is a new request taken
// a tick walks the channels in use: read-modify-write steps through the channel memory, then
//   one result per channel, one memory read per cycle while the output is not stalled
// reset: every channel off and silent, channels_in_use back to 8; the memory valid bits
//   clear at reset, so there is no clearing pass
module multi_channel_beep_flash_timer import mcbft_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int TIMEBASE_MS  = TIMEBASE_MS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_channels_in_use,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [MS_W-1:0]   i_active_time_ms,
    input  logic [MS_W-1:0]   i_flash_on_ms,
    input  logic [MS_W-1:0]   i_flash_off_ms,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CH_W-1:0]   o_out_channel,
    output logic [DRV_W-1:0]  o_drive_level,
    output logic [ST_W-1:0]   o_status,
    output logic              o_any_running,
    output logic              o_last
);

    // only channels below eight can ever be addressed
    localparam int MEM_DEPTH = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS : MAX_CHANNELS;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_CMD,
        S_ADV,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg;
    t_cmd                 r_mode;
    logic [CH_W-1:0]      r_chan;
    logic [MS_W-1:0]      r_active_ms;
    logic [MS_W-1:0]      r_on_ms;
    logic [MS_W-1:0]      r_off_ms;
    logic [CFG_W-1:0]     r_n;
    logic [AW-1:0]        r_idx;
    logic [MEM_DEPTH-1:0] r_run;
    logic [MEM_DEPTH-1:0] n_run;

    logic                 r_out_valid;
    logic [CH_W-1:0]      r_out_channel;
    logic [DRV_W-1:0]     r_drive_level;
    logic [ST_W-1:0]      r_status;
    logic                 r_any_running;
    logic                 r_last;

    logic [CFG_W-1:0]     w_n_cfg;
    logic [MEM_DEPTH-1:0] w_mask;
    logic                 w_out_free;
    logic                 w_in_fire;
    logic                 w_in_tick;
    logic                 w_chan_ok_in;
    logic                 w_chan_ok;
    logic                 w_idx_last;
    logic [AW-1:0]        w_idx_next;
    logic                 w_flash_err;

    logic [TICK_W-1:0]    w_act_t;
    logic [TICK_W-1:0]    w_on_t;
    logic [TICK_W-1:0]    w_off_t;

    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    t_chan_state          w_rd_data;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    t_chan_state          w_wr_data;
    t_chan_state          w_cmd_state;
    t_chan_state          w_adv_state;

    // ms to tick conversion, one unit per time field
    mcbft_ms2tick #(.TIMEBASE_MS(TIMEBASE_MS)) u_conv_act (
        .i_clk   (i_clk),
        .i_ms    (r_active_ms),
        .o_ticks (w_act_t)
    );

    mcbft_ms2tick #(.TIMEBASE_MS(TIMEBASE_MS)) u_conv_on (
        .i_clk   (i_clk),
        .i_ms    (r_on_ms),
        .o_ticks (w_on_t)
    );

    mcbft_ms2tick #(.TIMEBASE_MS(TIMEBASE_MS)) u_conv_off (
        .i_clk   (i_clk),
        .i_ms    (r_off_ms),
        .o_ticks (w_off_t)
    );

    // channel table
    mcbft_chan_mem #(.DEPTH(MEM_DEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_drive_level = r_drive_level;
    assign o_status      = r_status;
    assign o_any_running = r_any_running;
    assign o_last        = r_last;

    // count in use, limited to the table depth
    assign w_n_cfg = (r_cfg > CFG_W'(MEM_DEPTH)) ? CFG_W'(MEM_DEPTH) : r_cfg;

    always_comb begin
        for (int i = 0; i < MEM_DEPTH; i++) begin
            w_mask[i] = (CFG_W'(i) < r_n);
        end
    end

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_in_tick    = (i_mode == CMD_TICK);
    assign w_chan_ok_in = ({1'b0, i_channel} < w_n_cfg);
    assign w_chan_ok    = ({1'b0, r_chan} < r_n);
    assign w_idx_last   = ((CFG_W'(r_idx) + CFG_W'(1)) == r_n);
    assign w_idx_next   = w_idx_last ? '0 : r_idx + 1'b1;
    assign w_flash_err  = (w_on_t == '0) || (w_off_t == '0);

    assign w_adv_state  = chan_advance(w_rd_data);

    // command applied to the entry read at acceptance
    always_comb begin
        w_cmd_state = w_rd_data;
        case (r_mode)
            CMD_OFF: begin
                w_cmd_state.mode  = CHM_OFF;
                w_cmd_state.drive = DRV_SILENT;
            end
            CMD_ON: begin
                w_cmd_state.mode            = CHM_ON;
                w_cmd_state.remaining_ticks = w_act_t;
                w_cmd_state.drive           = DRV_FULL;
            end
            CMD_FLASH: begin
                if (!w_flash_err) begin
                    w_cmd_state.mode            = CHM_FLASH;
                    w_cmd_state.remaining_ticks = w_act_t;
                    w_cmd_state.on_phase_ticks  = w_on_t;
                    w_cmd_state.off_phase_ticks = w_off_t;
                    w_cmd_state.in_on_phase     = 1'b1;
                    w_cmd_state.phase_countdown = w_on_t;
                    w_cmd_state.drive           = DRV_HALF;
                end
            end
            default: begin
            end
        endcase
    end

    // memory port control
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = w_adv_state;
        case (r_state)
            S_IDLE: begin
                // tick starts at entry zero, a command reads its own entry
                w_rd_en   = w_in_fire && (w_in_tick ? (w_n_cfg != '0) : w_chan_ok_in);
                w_rd_addr = w_in_tick ? '0 : AW'(i_channel);
            end
            S_CMD: begin
                w_wr_en   = w_out_free && (r_mode != CMD_TICK) && w_chan_ok
                            && !(r_mode == CMD_FLASH && w_flash_err);
                w_wr_addr = AW'(r_chan);
                w_wr_data = w_cmd_state;
            end
            S_ADV: begin
                // write back this entry, fetch the next; wraps to zero for the result pass
                w_wr_en   = 1'b1;
                w_rd_en   = 1'b1;
                w_rd_addr = w_idx_next;
            end
            S_EMIT: begin
                w_rd_en   = w_out_free && !w_idx_last;
                w_rd_addr = w_idx_next;
            end
            default: begin
            end
        endcase
    end

    // running flags follow every write to the table
    always_comb begin
        n_run = r_run;
        if (w_wr_en) begin
            n_run[w_wr_addr] = chan_running(w_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
        end else begin
            r_run <= n_run;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_channels_in_use;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_mode      <= t_cmd'(i_mode);
                        r_chan      <= i_channel;
                        r_active_ms <= i_active_time_ms;
                        r_on_ms     <= i_flash_on_ms;
                        r_off_ms    <= i_flash_off_ms;
                        r_n         <= w_n_cfg;
                        r_idx       <= '0;
                        if (w_in_tick && w_n_cfg != '0) begin
                            r_state <= S_ADV;
                        end else begin
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    // tick times settle in the conversion registers
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_last        <= 1'b1;
                        r_any_running <= |(n_run & w_mask);
                        if (r_mode == CMD_TICK) begin
                            // tick with no channel in use
                            r_out_channel <= '0;
                            r_drive_level <= DRV_SILENT;
                            r_status      <= ST_NOT_IN_USE;
                        end else if (!w_chan_ok) begin
                            r_out_channel <= r_chan;
                            r_drive_level <= DRV_SILENT;
                            r_status      <= ST_NOT_IN_USE;
                        end else if (r_mode == CMD_FLASH && w_flash_err) begin
                            r_out_channel <= r_chan;
                            r_drive_level <= w_rd_data.drive;
                            r_status      <= ST_RANGE_ERR;
                        end else begin
                            r_out_channel <= r_chan;
                            r_drive_level <= w_cmd_state.drive;
                            r_status      <= ST_OK;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_ADV: begin
                    r_idx <= w_idx_next;
                    if (w_idx_last) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_channel <= CH_W'(r_idx);
                        r_drive_level <= w_rd_data.drive;
                        r_status      <= ST_OK;
                        r_any_running <= |(r_run & w_mask);
                        r_last        <= w_idx_last;
                        r_idx         <= w_idx_next;
                        if (w_idx_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // table writes only touch channels in use
    a_wr_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (CFG_W'(w_wr_addr) < r_n))
        else $error("table write outside channels in use");

    // the walk index stays inside the channels in use
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV || r_state == S_EMIT) |-> (CFG_W'(r_idx) < r_n))
        else $error("channel walk index out of range");

    // table writes happen only while applying a command or advancing
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_ADV || r_state == S_CMD))
        else $error("table write in wrong state");

    // loading a last result finishes the request
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMD || (r_state == S_EMIT && w_idx_last)) && w_out_free)
        |=> (r_state == S_IDLE && r_out_valid && r_last))
        else $error("last result did not end the request");

endmodule

// ----- tb/beep_report_checker.sv -----
`timescale 1ns / 100ps
module beep_report_checker import mcbft_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_channels_in_use,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [MS_W-1:0]   i_active_time_ms,
    input  logic [MS_W-1:0]   i_flash_on_ms,
    input  logic [MS_W-1:0]   i_flash_off_ms,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [CH_W-1:0]   i_out_channel,
    input  logic [DRV_W-1:0]  i_drive_level,
    input  logic [ST_W-1:0]   i_status,
    input  logic              i_any_running,
    input  logic              i_last,
    output int                o_mismatches,
    output int                o_reports_due
);

    typedef struct packed {
        logic [CH_W-1:0]  chan;
        logic [DRV_W-1:0] drive;
        logic [ST_W-1:0]  status;
        logic             running;
        logic             last;
    } t_drive_report;

    t_drive_report     reports_due_q[$];
    t_drive_report     want_r;
    logic [CFG_W-1:0]  chans_cfg = CFG_RESET;
    logic [CHM_W-1:0]  chan_mode  [MAX_CHANNELS];
    logic [TICK_W-1:0] ticks_left [MAX_CHANNELS];
    logic [TICK_W-1:0] on_len     [MAX_CHANNELS];
    logic [TICK_W-1:0] off_len    [MAX_CHANNELS];
    logic [TICK_W-1:0] phase_left [MAX_CHANNELS];
    logic              sounding   [MAX_CHANNELS];
    logic [DRV_W-1:0]  drive_lvl  [MAX_CHANNELS];
    int                mismatch_cnt = 0;

    initial begin
        o_mismatches  = 0;
        o_reports_due = 0;
    end

    function automatic int unsigned chans_in_use();
        int unsigned n;
        n = chans_cfg;
        if (n > NUM_CHANNELS_DEF) n = NUM_CHANNELS_DEF;
        if (n > MAX_CHANNELS) n = MAX_CHANNELS;
        return n;
    endfunction

    function automatic logic [TICK_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        return TICK_W'(ms / TIMEBASE_MS_DEF);
    endfunction

    function automatic logic any_chan_busy();
        logic busy;
        busy = 1'b0;
        for (int unsigned c = 0; c < chans_in_use(); c++) begin
            if (chan_mode[c] == CHM_FLASH) busy = 1'b1;
            if (chan_mode[c] == CHM_ON && ticks_left[c] != '0) busy = 1'b1;
        end
        return busy;
    endfunction

    task automatic push_report(input logic [CH_W-1:0] ch, input logic [DRV_W-1:0] drv,
                               input logic [ST_W-1:0] st, input logic last);
        t_drive_report r;
        r.chan    = ch;
        r.drive   = drv;
        r.status  = st;
        r.running = any_chan_busy();
        r.last    = last;
        reports_due_q.push_back(r);
    endtask

    task automatic predict_reports(input logic [1:0] mode, input logic [CH_W-1:0] ch,
                                   input logic [MS_W-1:0] act_ms,
                                   input logic [MS_W-1:0] on_ms,
                                   input logic [MS_W-1:0] off_ms);
        int unsigned       n;
        logic [TICK_W-1:0] on_t;
        logic [TICK_W-1:0] off_t;
        n     = chans_in_use();
        on_t  = ms_to_ticks(on_ms);
        off_t = ms_to_ticks(off_ms);
        if (t_cmd'(mode) == CMD_TICK) begin
            if (n == 0) begin
                push_report('0, DRV_SILENT, ST_NOT_IN_USE, 1'b1);
            end else begin
                for (int unsigned c = 0; c < n; c++) begin
                    // idle channels and permanent on channels do not move
                    if (chan_mode[c] == CHM_FLASH ||
                        (chan_mode[c] == CHM_ON && ticks_left[c] != '0)) begin
                        if (ticks_left[c] != '0) begin
                            ticks_left[c] = ticks_left[c] - 1'b1;
                            if (ticks_left[c] == '0) begin
                                chan_mode[c] = CHM_OFF;
                                drive_lvl[c] = DRV_SILENT;
                            end
                        end
                        if (chan_mode[c] == CHM_FLASH) begin
                            if (phase_left[c] != '0) phase_left[c] = phase_left[c] - 1'b1;
                            if (phase_left[c] == '0) begin
                                sounding[c]   = !sounding[c];
                                drive_lvl[c]  = sounding[c] ? DRV_HALF : DRV_SILENT;
                                phase_left[c] = sounding[c] ? on_len[c] : off_len[c];
                            end
                        end
                    end
                end
                for (int unsigned c = 0; c < n; c++)
                    push_report(CH_W'(c), drive_lvl[c], ST_OK, c + 1 == n);
            end
        end else if (ch >= n) begin
            push_report(ch, DRV_SILENT, ST_NOT_IN_USE, 1'b1);
        end else begin
            case (t_cmd'(mode))
                CMD_OFF: begin
                    chan_mode[ch] = CHM_OFF;
                    drive_lvl[ch] = DRV_SILENT;
                    push_report(ch, drive_lvl[ch], ST_OK, 1'b1);
                end
                CMD_ON: begin
                    chan_mode[ch]  = CHM_ON;
                    ticks_left[ch] = ms_to_ticks(act_ms);
                    drive_lvl[ch]  = DRV_FULL;
                    push_report(ch, drive_lvl[ch], ST_OK, 1'b1);
                end
                default: begin
                    if (on_t == '0 || off_t == '0) begin
                        push_report(ch, drive_lvl[ch], ST_RANGE_ERR, 1'b1);
                    end else begin
                        chan_mode[ch]  = CHM_FLASH;
                        ticks_left[ch] = ms_to_ticks(act_ms);
                        on_len[ch]     = on_t;
                        off_len[ch]    = off_t;
                        sounding[ch]   = 1'b1;
                        phase_left[ch] = on_t;
                        drive_lvl[ch]  = DRV_HALF;
                        push_report(ch, drive_lvl[ch], ST_OK, 1'b1);
                    end
                end
            endcase
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chans_cfg = CFG_RESET;
            reports_due_q.delete();
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                chan_mode[c]  = CHM_OFF;
                ticks_left[c] = '0;
                on_len[c]     = '0;
                off_len[c]    = '0;
                phase_left[c] = '0;
                sounding[c]   = 1'b0;
                drive_lvl[c]  = DRV_SILENT;
            end
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (reports_due_q.size() == 0) begin
                    $error("unexpected result: out_channel %0d", i_out_channel);
                    mismatch_cnt++;
                end else begin
                    want_r = reports_due_q.pop_front();
                    compare_field("out_channel", want_r.chan, i_out_channel);
                    compare_field("drive_level", want_r.drive, i_drive_level);
                    compare_field("status", want_r.status, i_status);
                    compare_field("any_running", want_r.running, i_any_running);
                    compare_field("last", want_r.last, i_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                chans_cfg = i_cfg_channels_in_use;
            if (i_in_valid && i_in_ready)
                predict_reports(i_mode, i_channel, i_active_time_ms, i_flash_on_ms,
                                i_flash_off_ms);
        end
        o_mismatches  <= mismatch_cnt;
        o_reports_due <= reports_due_q.size();
    end

endmodule

// ----- tb/tb_multi_channel_beep_flash_timer.sv -----
`timescale 1ns / 100ps
module tb_multi_channel_beep_flash_timer;
    import mcbft_pkg::*;

    // cycles without any accepted transfer before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // settle time after the last result: a full tick walk plus margin
    localparam int QUIET_CYCLES = 2 * MAX_CHANNELS + 4;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 32;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_chans = CFG_RESET;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        req_mode = CMD_TICK;
    logic [CH_W-1:0]   req_channel = '0;
    logic [MS_W-1:0]   req_active_ms = '0;
    logic [MS_W-1:0]   req_on_ms = '0;
    logic [MS_W-1:0]   req_off_ms = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CH_W-1:0]   out_channel;
    logic [DRV_W-1:0]  drive_level;
    logic [ST_W-1:0]   status;
    logic              any_running;
    logic              last;

    int                mismatches;
    int                reports_due;
    int unsigned       send_idle_pct = 0;
    int unsigned       ready_stall_pct = 0;
    int unsigned       cur_chans = CFG_RESET;
    int unsigned       quiet_cycles = 0;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_channel_beep_flash_timer dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (cfg_ready),
        .i_cfg_channels_in_use (cfg_chans),
        .i_in_valid            (in_valid),
        .o_in_ready            (in_ready),
        .i_mode                (req_mode),
        .i_channel             (req_channel),
        .i_active_time_ms      (req_active_ms),
        .i_flash_on_ms         (req_on_ms),
        .i_flash_off_ms        (req_off_ms),
        .o_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .o_out_channel         (out_channel),
        .o_drive_level         (drive_level),
        .o_status              (status),
        .o_any_running         (any_running),
        .o_last                (last)
    );

    beep_report_checker u_checker (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_valid           (cfg_valid),
        .i_cfg_ready           (cfg_ready),
        .i_cfg_channels_in_use (cfg_chans),
        .i_in_valid            (in_valid),
        .i_in_ready            (in_ready),
        .i_mode                (req_mode),
        .i_channel             (req_channel),
        .i_active_time_ms      (req_active_ms),
        .i_flash_on_ms         (req_on_ms),
        .i_flash_off_ms        (req_off_ms),
        .i_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .i_out_channel         (out_channel),
        .i_drive_level         (drive_level),
        .i_status              (status),
        .i_any_running         (any_running),
        .i_last                (last),
        .o_mismatches          (mismatches),
        .o_reports_due         (reports_due)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // hang detection: any accepted transfer on any channel restarts the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request; valid stays up into the next request when no gap is drawn
    task automatic send_request(input t_cmd mode, input logic [CH_W-1:0] ch,
                                input logic [MS_W-1:0] act_ms,
                                input logic [MS_W-1:0] on_ms,
                                input logic [MS_W-1:0] off_ms);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_mode      <= mode;
        req_channel   <= ch;
        req_active_ms <= act_ms;
        req_on_ms     <= on_ms;
        req_off_ms    <= off_ms;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold off requests until every pending result is out, then settle
    task automatic wait_results_drained(input int unsigned settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_channel_count(input logic [CFG_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_chans <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_chans = count;
    endtask

    // mostly short well-formed timings so channels expire and flash phases flip
    task automatic random_request();
        int unsigned       pick;
        int unsigned       n;
        t_cmd              mode;
        logic [CH_W-1:0]   ch;
        logic [MS_W-1:0]   act_ms;
        logic [MS_W-1:0]   on_ms;
        logic [MS_W-1:0]   off_ms;
        pick = $urandom_range(99);
        if (pick < 40) mode = CMD_TICK;
        else if (pick < 55) mode = CMD_OFF;
        else if (pick < 75) mode = CMD_ON;
        else mode = CMD_FLASH;
        n = (cur_chans > MAX_CHANNELS) ? MAX_CHANNELS : cur_chans;
        // mostly channels in use, sometimes any channel
        if (n != 0 && $urandom_range(9) < 8) ch = CH_W'($urandom_range(n - 1));
        else ch = CH_W'($urandom_range(7));
        case ($urandom_range(9))
            6, 7:    act_ms = '0;
            8:       act_ms = MS_W'($urandom_range(9));
            9:       act_ms = MS_W'($urandom_range(65535));
            default: act_ms = MS_W'($urandom_range(120));
        endcase
        case ($urandom_range(9))
            7:       on_ms = MS_W'($urandom_range(9));
            8:       on_ms = '0;
            9:       on_ms = MS_W'($urandom_range(65535));
            default: on_ms = MS_W'($urandom_range(50, 10));
        endcase
        case ($urandom_range(9))
            7:       off_ms = MS_W'($urandom_range(9));
            8:       off_ms = '0;
            9:       off_ms = MS_W'($urandom_range(65535));
            default: off_ms = MS_W'($urandom_range(50, 10));
        endcase
        send_request(mode, ch, act_ms, on_ms, off_ms);
        // now and then the sender waits for the block to empty completely
        if ($urandom_range(39) == 0) wait_results_drained(0);
    endtask

    initial begin
        int unsigned chan_plan [NUM_PHASES];
        chan_plan = '{8, 1, 0, 15, 3, 8, 5, 2};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset channel count of 8
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);        // all off
        send_request(CMD_ON, 3'd0, 16'd0, 16'd0, 16'd0);          // permanent on
        send_request(CMD_ON, 3'd1, 16'd30, 16'd0, 16'd0);         // on for three ticks
        send_request(CMD_ON, 3'd2, 16'd9, 16'd0, 16'd0);          // rounds to permanent
        send_request(CMD_FLASH, 3'd3, 16'd0, 16'd20, 16'd30);     // endless flash
        send_request(CMD_FLASH, 3'd4, 16'd40, 16'd0, 16'd20);     // zero sounding time
        send_request(CMD_FLASH, 3'd4, 16'd40, 16'd20, 16'd0);     // zero silent time
        send_request(CMD_FLASH, 3'd4, 16'd40, 16'd5, 16'd20);     // sounding rounds to zero
        send_request(CMD_FLASH, 3'd0, 16'd0, 16'd20, 16'd9);      // range error keeps full drive
        send_request(CMD_FLASH, 3'd5, 16'hffff, 16'hffff, 16'hffff);
        send_request(CMD_FLASH, 3'd7, 16'd50, 16'd10, 16'd10);    // fast flash, expires
        repeat (6) send_request(CMD_TICK, 3'd7, 16'hffff, 16'hffff, 16'hffff);
        send_request(CMD_OFF, 3'd0, 16'd0, 16'd0, 16'd0);
        send_request(CMD_OFF, 3'd3, 16'd0, 16'd0, 16'd0);
        send_request(CMD_FLASH, 3'd3, 16'd0, 16'd20, 16'd9);      // range error while silent
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
        send_request(CMD_ON, 3'd6, 16'hffff, 16'd0, 16'd0);
        send_request(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);

        // random phases, each with its own channel count and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_results_drained(QUIET_CYCLES);
            write_channel_count(CFG_W'(chan_plan[p]));
            case (p % 4)
                0: begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 0;
                end
                1: begin
                    send_idle_pct   = 47;
                    ready_stall_pct = 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 47;
                end
                default: begin
                    send_idle_pct   = 35;
                    ready_stall_pct = 35;
                end
            endcase
            repeat (PHASE_ITEMS) random_request();
        end

        wait_results_drained(QUIET_CYCLES);
        if (mismatches == 0 && reports_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mcbft_pkg.sv
hdl/mcbft_ms2tick.sv
hdl/mcbft_chan_mem.sv
hdl/multi_channel_beep_flash_timer.sv
tb/beep_report_checker.sv
tb/tb_multi_channel_beep_flash_timer.sv
